// ----- design/bbp_pkg.sv -----
// Shared types and constants for the bimodal branch predictor.
// No dependencies; imported by bbp_ram and bimodal_branch_predictor.
package bbp_pkg;

    localparam int PC_W                  = 64;
    localparam int CNT_W                 = 32;
    localparam int ENTRY_W               = 2;
    localparam int TABLE_ENTRIES_DEFAULT = 1024;

    // command codes
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // predictor_mode register codes
    localparam logic MODE_ONE_BIT  = 1'b0;
    localparam logic MODE_BIMODAL  = 1'b1;
    localparam logic MODE_RESET    = MODE_BIMODAL;

    // 2-bit entry values
    localparam logic [ENTRY_W-1:0] ENTRY_MIN       = 2'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_ONE       = 2'd1;
    localparam logic [ENTRY_W-1:0] ENTRY_NOT_TAKEN = 2'd1;
    localparam logic [ENTRY_W-1:0] ENTRY_TAKEN     = 2'd2;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX       = 2'd3;
    localparam logic [ENTRY_W-1:0] ENTRY_INIT      = ENTRY_NOT_TAKEN;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef struct packed {
        logic            cmd;
        logic [PC_W-1:0] pc;
        logic            taken;
    } t_bbp_in;

    typedef struct packed {
        logic             predict_taken;
        logic             was_correct;
        logic [CNT_W-1:0] prediction_count;
        logic [CNT_W-1:0] correct_count;
        logic [CNT_W-1:0] mispredict_count;
    } t_bbp_out;

endpackage

// ----- design/bimodal_branch_predictor.sv -----
// Bimodal branch direction predictor, top level.
// Depends on bbp_pkg and bbp_ram (pattern table storage).
//
// Takes predict and update beats and returns one result beat per input beat:
// the accepting edge reads the pattern table RAM (registered read) into
// stage 1; when stage 1 advances it evaluates the entry, writes it back and
// loads the result register. Throughput is one beat per cycle while the
// result channel does not stall; the single table write port and the
// one-entry bypass from the last write keep back-to-back beats to the same
// entry coherent. After reset the table is swept to "weakly not taken" one
// entry per cycle, so o_in_ready stays low until every entry is written; the
// mode register can be written at any time, including during that sweep.
// The table index is pc[IDX_W+1:2]. Statistics counters are 32 bits and wrap.
module bimodal_branch_predictor
    import bbp_pkg::*;
#(
    parameter  int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
    localparam int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input channel
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_bbp_in  i_in_data,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_bbp_out o_out_data,
    // mode register write channel
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    // ---------------- control / state registers ----------------
    logic             r_mode;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic             r_s1_cmd;
    logic             r_s1_taken;
    logic [IDX_W-1:0] r_s1_idx;

    // bypass of the most recent table write (covers read/write same edge)
    logic               r_fwd_valid;
    logic [IDX_W-1:0]   r_fwd_idx;
    logic [ENTRY_W-1:0] r_fwd_data;

    logic             r_out_valid;
    t_bbp_out         r_out;

    logic [CNT_W-1:0] r_pred_cnt;
    logic [CNT_W-1:0] r_corr_cnt;
    logic [CNT_W-1:0] r_wrong_cnt;

    // ---------------- combinational ----------------
    logic               in_fire;
    logic               s1_adv;
    logic               s1_fire;
    logic [IDX_W-1:0]   in_idx;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry;
    logic               guess;
    logic               is_update;
    logic               right;
    logic [ENTRY_W-1:0] n_entry;
    logic [CNT_W-1:0]   n_pred_cnt;
    logic [CNT_W-1:0]   n_corr_cnt;
    logic [CNT_W-1:0]   n_wrong_cnt;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    assign in_idx     = i_in_data.pc[IDX_W+1:2];
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // entry as seen by the beat in stage 1
    assign entry = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_data : ram_rdata;
    assign guess     = entry[ENTRY_W-1];   // entry >= 2
    assign is_update = (r_s1_cmd == CMD_UPDATE);
    assign right     = is_update && (guess == r_s1_taken);

    always_comb begin
        n_entry = entry;
        unique case (r_mode)
            MODE_BIMODAL: begin
                if (r_s1_taken) begin
                    if (entry != ENTRY_MAX) n_entry = entry + ENTRY_ONE;
                end else begin
                    if (entry != ENTRY_MIN) n_entry = entry - ENTRY_ONE;
                end
            end
            MODE_ONE_BIT: begin
                n_entry = r_s1_taken ? ENTRY_TAKEN : ENTRY_NOT_TAKEN;
            end
            default: n_entry = entry;
        endcase
    end

    assign n_pred_cnt  = is_update ? r_pred_cnt : r_pred_cnt + CNT_ONE;
    assign n_corr_cnt  = right ? r_corr_cnt + CNT_ONE : r_corr_cnt;
    assign n_wrong_cnt = (is_update && !right) ? r_wrong_cnt + CNT_ONE : r_wrong_cnt;

    // table write port: clearing sweep or stage-1 update
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = ENTRY_INIT;
        end else begin
            ram_we    = s1_fire && is_update;
            ram_waddr = r_s1_idx;
            ram_wdata = n_entry;
        end
    end

    bbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pred_cnt  <= '0;
            r_corr_cnt  <= '0;
            r_wrong_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_pred_cnt  <= n_pred_cnt;
                r_corr_cnt  <= n_corr_cnt;
                r_wrong_cnt <= n_wrong_cnt;
                if (is_update) begin
                    r_fwd_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd   <= i_in_data.cmd;
            r_s1_taken <= i_in_data.taken;
            r_s1_idx   <= in_idx;
        end
        if (s1_fire) begin
            r_out.predict_taken    <= guess;
            r_out.was_correct      <= right;
            r_out.prediction_count <= n_pred_cnt;
            r_out.correct_count    <= n_corr_cnt;
            r_out.mispredict_count <= n_wrong_cnt;
            if (is_update) begin
                r_fwd_idx  <= r_s1_idx;
                r_fwd_data <= n_entry;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- design/bbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on bbp_pkg for default sizes only.
module bbp_ram
    import bbp_pkg::*;
#(
    parameter  int WIDTH  = ENTRY_W,
    parameter  int DEPTH  = TABLE_ENTRIES_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for bimodal_branch_predictor: directed table, then random beats.
// Depends on bbp_pkg (beat structs, command, mode and entry codes) and the RTL under design/.
module tb;
    import bbp_pkg::*;

    localparam int          IDX_W           = $clog2(TABLE_ENTRIES_DEFAULT);
    localparam int          PHASES          = 6;
    localparam int          BEATS_PER_PHASE = 280;
    localparam int          TAIL_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          LOUD_MISMATCHES = 10;

    localparam logic [PC_W-1:0] PC_ALL_ONES = '1;
    localparam logic [PC_W-1:0] PC_ALIAS_0  = 64'h0000_0000_0000_1000; // wraps onto entry 0
    localparam logic [PC_W-1:0] PC_TOP_BIT  = 64'h8000_0000_0000_0003; // low bits dropped
    localparam logic [PC_W-1:0] PC_ENTRY_1  = 64'h4;
    localparam logic [PC_W-1:0] PC_ENTRY_2  = 64'h8;
    localparam t_bbp_out        NO_WANT     = '0;

    // directed rows: typed expectation, predictor expectation, or mode write
    typedef enum logic [1:0] {ROW_CHECKED, ROW_MODELED, ROW_MODE} t_row_kind;

    // mode rows carry the new mode in beat.taken
    typedef struct packed {
        t_row_kind kind;
        t_bbp_in   beat;
        t_bbp_out  want;
    } t_dir_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_ONE_IN_THREE, RX_RARE_STALL} t_rx_style;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_bbp_in  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_bbp_out out_data;
    logic     cfg_ready;

    // shadow of the predictor state, advanced at each accepted input beat
    logic [ENTRY_W-1:0] shadow_pht [TABLE_ENTRIES_DEFAULT];
    logic               mode_shadow;
    logic [CNT_W-1:0]   predictions_seen;
    logic [CNT_W-1:0]   hits_seen;
    logic [CNT_W-1:0]   misses_seen;

    t_bbp_out    pending_results [$];
    t_dir_row    rows [$];
    int unsigned mismatches = 0;
    int unsigned cycle_no   = 0;
    int          burst_left = 0;
    t_rx_style   rx_style   = RX_OPEN;
    int          rx_left    = 0;

    bimodal_branch_predictor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected result of one accepted beat; updates the shadow table and counters.
    function automatic t_bbp_out resolve_branch(input t_bbp_in b);
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] ent;
        t_bbp_out           r;
        idx = b.pc[IDX_W+1:2];
        ent = shadow_pht[idx];
        r = '0;
        r.predict_taken = (ent >= ENTRY_TAKEN);
        if (b.cmd == CMD_PREDICT) begin
            predictions_seen = predictions_seen + CNT_ONE;
        end else begin
            r.was_correct = (r.predict_taken == b.taken);
            if (r.was_correct) begin
                hits_seen = hits_seen + CNT_ONE;
            end else begin
                misses_seen = misses_seen + CNT_ONE;
            end
            if (mode_shadow == MODE_BIMODAL) begin
                // saturating up/down counter
                if (b.taken && ent != ENTRY_MAX) begin
                    ent = ent + 2'd1;
                end else if (!b.taken && ent != ENTRY_MIN) begin
                    ent = ent - 2'd1;
                end
            end else begin
                // one-bit mode: remember the last outcome only
                ent = b.taken ? ENTRY_TAKEN : ENTRY_NOT_TAKEN;
            end
            shadow_pht[idx] = ent;
        end
        r.prediction_count = predictions_seen;
        r.correct_count    = hits_seen;
        r.mispredict_count = misses_seen;
        return r;
    endfunction

    // Random beat: mostly a few hot branches with a per-branch bias so the
    // counters saturate both ways, plus the top entry and fully random pcs.
    function automatic t_bbp_in random_branch();
        t_bbp_in b;
        int      sel;
        int      slot;
        int      bias;
        b.cmd = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_PREDICT;
        b.pc  = {$urandom, $urandom};
        sel   = $urandom_range(0, 9);
        bias  = 50;
        if (sel < 7) begin
            slot = $urandom_range(0, 15);
            b.pc[IDX_W+1:2] = IDX_W'(slot * 67);
            bias = slot[0] ? 85 : 15;
        end else if (sel == 7) begin
            b.pc[IDX_W+1:2] = '1;
        end
        b.taken = ($urandom_range(0, 99) < bias);
        return b;
    endfunction

    // Holds one input beat until accepted, then queues its expected result.
    task automatic push_beat(input t_bbp_in b, input logic typed, input t_bbp_out want);
        t_bbp_out predicted;
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = resolve_branch(b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Sender pacing: bursts of back-to-back beats separated by idle gaps.
    task automatic pace_sender();
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    // Mode writes only land with nothing in flight.
    task automatic set_mode_when_idle(input logic m);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        mode_shadow = m;
        cfg_valid <= 1'b0;
    endtask

    // Receiver: the stall style is redrawn at random; each result beat is checked.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 3));
            rx_left  <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN:         out_ready <= 1'b1;
            RX_COIN:         out_ready <= $urandom_range(0, 1);
            RX_ONE_IN_THREE: out_ready <= (cycle_no % 3 == 0);
            default:         out_ready <= ($urandom_range(0, 7) != 0);
        endcase

        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < LOUD_MISMATCHES) begin
                    $display("mismatch: result beat with nothing expected, got pt=%0d ok=%0d",
                             out_data.predict_taken, out_data.was_correct);
                end
                mismatches++;
            end else begin
                t_bbp_out want;
                want = pending_results.pop_front();
                if (out_data.predict_taken    !== want.predict_taken    ||
                    out_data.was_correct      !== want.was_correct      ||
                    out_data.prediction_count !== want.prediction_count ||
                    out_data.correct_count    !== want.correct_count    ||
                    out_data.mispredict_count !== want.mispredict_count) begin
                    if (mismatches < LOUD_MISMATCHES) begin
                        $display("mismatch: want pt=%0d ok=%0d n=%0d hit=%0d miss=%0d",
                                 want.predict_taken, want.was_correct, want.prediction_count,
                                 want.correct_count, want.mispredict_count);
                        $display("          got  pt=%0d ok=%0d n=%0d hit=%0d miss=%0d",
                                 out_data.predict_taken, out_data.was_correct,
                                 out_data.prediction_count, out_data.correct_count,
                                 out_data.mispredict_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. The post-reset table sweep is well inside the limit.
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES_DEFAULT; i++) begin
            shadow_pht[i] = ENTRY_INIT;
        end
        mode_shadow      = MODE_RESET;
        predictions_seen = '0;
        hits_seen        = '0;
        misses_seen      = '0;

        // Bimodal mode out of reset: walk entry 0 up to saturation, the top
        // entry down to saturation, then alias onto entry 0.
        rows.push_back({ROW_CHECKED, CMD_PREDICT, 64'h0, 1'b0, 1'b0, 1'b0, 32'd1, 32'd0, 32'd0});
        rows.push_back({ROW_CHECKED, CMD_PREDICT, PC_ALL_ONES, 1'b0,
                        1'b0, 1'b0, 32'd2, 32'd0, 32'd0});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b1, 1'b0, 1'b0, 32'd2, 32'd0, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b1, 1'b1, 1'b1, 32'd2, 32'd1, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b1, 1'b1, 1'b1, 32'd2, 32'd2, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_PREDICT, 64'h0, 1'b0, 1'b1, 1'b0, 32'd3, 32'd2, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, PC_ALL_ONES, 1'b0,
                        1'b0, 1'b1, 32'd3, 32'd3, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, PC_ALL_ONES, 1'b0,
                        1'b0, 1'b1, 32'd3, 32'd4, 32'd1});
        // taken is a don't-care on predict
        rows.push_back({ROW_CHECKED, CMD_PREDICT, PC_ALL_ONES, 1'b1,
                        1'b0, 1'b0, 32'd4, 32'd4, 32'd1});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, PC_ALIAS_0, 1'b0,
                        1'b1, 1'b0, 32'd4, 32'd4, 32'd2});
        rows.push_back({ROW_CHECKED, CMD_PREDICT, PC_TOP_BIT, 1'b0,
                        1'b1, 1'b0, 32'd5, 32'd4, 32'd2});
        // One-bit mode keeps the table; a saturated-low entry still predicts not taken.
        rows.push_back({ROW_MODE, CMD_PREDICT, 64'h0, MODE_ONE_BIT, NO_WANT});
        rows.push_back({ROW_CHECKED, CMD_PREDICT, PC_ALL_ONES, 1'b0,
                        1'b0, 1'b0, 32'd6, 32'd4, 32'd2});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b0, 1'b1, 1'b0, 32'd6, 32'd4, 32'd3});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b1, 1'b0, 1'b0, 32'd6, 32'd4, 32'd4});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, 64'h0, 1'b1, 1'b1, 1'b1, 32'd6, 32'd5, 32'd4});
        rows.push_back({ROW_CHECKED, CMD_UPDATE, PC_ENTRY_1, 1'b1,
                        1'b0, 1'b0, 32'd6, 32'd5, 32'd5});
        // Saturate an entry high in bimodal mode, then read and overwrite it in one-bit mode.
        rows.push_back({ROW_MODE, CMD_PREDICT, 64'h0, MODE_BIMODAL, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_UPDATE, PC_ENTRY_2, 1'b1, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_UPDATE, PC_ENTRY_2, 1'b1, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_UPDATE, PC_ENTRY_2, 1'b1, NO_WANT});
        rows.push_back({ROW_MODE, CMD_PREDICT, 64'h0, MODE_ONE_BIT, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_PREDICT, PC_ENTRY_2, 1'b0, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_UPDATE, PC_ENTRY_2, 1'b0, NO_WANT});
        rows.push_back({ROW_MODELED, CMD_PREDICT, PC_ENTRY_2, 1'b1, NO_WANT});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_MODE) begin
                set_mode_when_idle(rows[i].beat.taken);
            end else begin
                push_beat(rows[i].beat, rows[i].kind == ROW_CHECKED, rows[i].want);
                pace_sender();
            end
        end

        // Random phases, alternating the mode so both settings see long runs.
        for (int p = 0; p < PHASES; p++) begin
            set_mode_when_idle(p[0] ? MODE_BIMODAL : MODE_ONE_BIT);
            repeat (BEATS_PER_PHASE) begin
                push_beat(random_branch(), 1'b0, NO_WANT);
                pace_sender();
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // catch any stray result beat after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/bbp_pkg.sv
design/bbp_ram.sv
design/bimodal_branch_predictor.sv
tb/sv/tb.sv
